// ===== design/dfd_pkg.sv =====
// Shared types, constants and arithmetic helpers for the damped feedback delay.
// No dependencies; imported by every module of the block.
`default_nettype none

package dfd_pkg;

    localparam int DATA_W              = 16;
    localparam int DELAY_W             = 17;
    localparam int GAIN_W              = 15;
    localparam int MIX_W               = 16;
    localparam int CFG_DATA_W          = 17;
    localparam int CFG_INDEX_W         = 2;
    localparam int LINE_ADDR_BITS_DEF  = 17;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DAMPING  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIX      = 2'd3;

    // Coefficient limits (0.95, 0.99 and 1.0)
    localparam logic [GAIN_W-1:0] FEEDBACK_MAX = 15'd31130;
    localparam logic [GAIN_W-1:0] DAMPING_MAX  = 15'd32440;
    localparam logic [MIX_W-1:0]  MIX_MAX      = 16'd32768;
    localparam logic signed [DATA_W:0] ONE_Q15 = 17'sd32768;

    localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 16'sd32767;
    localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Coefficients used by the multiply-accumulate stage
    typedef struct packed {
        logic [GAIN_W-1:0] damping;
        logic [MIX_W-1:0]  mix;
    } dfd_coef_t;

    // Clamp an 18-bit signed value to the Q1.15 sample range
    function automatic logic signed [DATA_W-1:0] sat_q15(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 18'sd32767)
            r = SAMPLE_MAX;
        else if (v < -18'sd32768)
            r = SAMPLE_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/damped_feedback_delay.sv =====
// Top level of the damped feedback delay: control, config registers, feedback path.
// Depends on dfd_pkg, dfd_line_mem and dfd_mac.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+---------------------------------
//   input    | s_axis_tvalid / s_axis_tready | s_axis_tdata[15:0] in_sample
//   output   | m_axis_tvalid / m_axis_tready | m_axis_tdata[15:0] out_sample
//   config   | cfg_we                        | cfg_index, cfg_data
//
// Each beat passes accept (the line read is issued there), the multiply-accumulate
// state and the write-back state; the feedback write-back shares its cycle with the
// read of the next beat (forwarded when both hit the same entry). No sample is
// accepted in the multiply-accumulate state. Reset needs no clearing pass:
// entries not yet written since reset read as zero through a wrap flag.
// A stalled output holds its result and blocks only the following accept.
`default_nettype none

module damped_feedback_delay #(
    parameter int LINE_ADDR_BITS = dfd_pkg::LINE_ADDR_BITS_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // in_sample [15:0]
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire [dfd_pkg::DATA_W-1:0]             s_axis_tdata,
    // out_sample [15:0]
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [dfd_pkg::DATA_W-1:0]            m_axis_tdata,
    input  wire                                   cfg_we,
    input  wire [dfd_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire [dfd_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import dfd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic [LINE_ADDR_BITS-1:0] wi_reg;
    logic                      wrapped_reg;
    logic [LINE_ADDR_BITS-1:0] wr_addr_reg;
    logic signed [DATA_W-1:0]  x_reg;
    logic signed [DATA_W-1:0]  lp_reg;
    logic signed [DATA_W-1:0]  y_reg;
    logic                      out_valid_reg;
    logic                      fwd_hit_reg;
    logic signed [DATA_W-1:0]  fwd_data_reg;
    logic                      rd_valid_reg;

    logic [DELAY_W-1:0]        dly_reg;
    logic [GAIN_W-1:0]         fb_reg;
    logic [GAIN_W-1:0]         dmp_reg;
    logic [MIX_W-1:0]          mix_reg;

    logic                      accept;
    logic                      wr_en;
    logic [LINE_ADDR_BITS-1:0] rd_addr;
    logic signed [DATA_W-1:0]  rd_data;
    logic signed [DATA_W-1:0]  delayed;
    logic signed [DATA_W-1:0]  lp_next;
    logic signed [DATA_W-1:0]  wet_out;
    logic signed [2*DATA_W-1:0] fb_prod;
    logic signed [DATA_W+1:0]  fed_sum;
    logic signed [DATA_W-1:0]  fed;
    logic [GAIN_W-1:0]         cfg_gain;
    logic [MIX_W-1:0]          cfg_mix;
    logic [DELAY_W-1:0]        cfg_dly;
    dfd_coef_t                 coef;

    // Handshake
    assign s_axis_tready = (state_reg != ST_MAC) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = y_reg;

    // Configuration writes, clamped to their legal ranges
    assign cfg_gain = cfg_data[GAIN_W-1:0];
    assign cfg_mix  = cfg_data[MIX_W-1:0];
    assign cfg_dly  = cfg_data[DELAY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dly_reg <= DELAY_W'(1);
            fb_reg  <= '0;
            dmp_reg <= '0;
            mix_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DELAY:
                begin
                    dly_reg <= (cfg_dly == '0) ? DELAY_W'(1) : cfg_dly;
                end
                REG_FEEDBACK:
                begin
                    fb_reg <= (cfg_gain > FEEDBACK_MAX) ? FEEDBACK_MAX : cfg_gain;
                end
                REG_DAMPING:
                begin
                    dmp_reg <= (cfg_gain > DAMPING_MAX) ? DAMPING_MAX : cfg_gain;
                end
                REG_MIX:
                begin
                    mix_reg <= (cfg_mix > MIX_MAX) ? MIX_MAX : cfg_mix;
                end
                default:
                begin
                    dly_reg <= dly_reg;
                end
            endcase
        end
    end

    // Sequencer: accept/read, multiply-accumulate, write back
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = accept ? ST_MAC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Line addressing and feedback write
    assign rd_addr = wi_reg - LINE_ADDR_BITS'(dly_reg);
    assign wr_en   = (state_reg == ST_WRITE);

    assign fb_prod = $signed({1'b0, fb_reg}) * lp_reg;
    assign fed_sum = $signed({{2{x_reg[DATA_W-1]}}, x_reg})
                     + $signed({fb_prod[2*DATA_W-1], fb_prod[2*DATA_W-1:DATA_W-1]});
    assign fed     = sat_q15(fed_sum);

    dfd_line_mem #(
        .ADDR_BITS (LINE_ADDR_BITS)
    ) u_line (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr_reg),
        .wr_data (fed),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pick forwarded, stored or never-written (zero) data
    always_comb
    begin
        if (fwd_hit_reg)
            delayed = fwd_data_reg;
        else if (rd_valid_reg)
            delayed = rd_data;
        else
            delayed = '0;
    end

    assign coef.damping = dmp_reg;
    assign coef.mix     = mix_reg;

    dfd_mac u_mac (
        .delayed (delayed),
        .dry     (x_reg),
        .lp      (lp_reg),
        .coef    (coef),
        .lp_next (lp_next),
        .wet_out (wet_out)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wi_reg        <= '0;
            wrapped_reg   <= 1'b0;
            lp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MAC)
            begin
                wi_reg        <= wi_reg + LINE_ADDR_BITS'(1);
                lp_reg        <= lp_next;
                out_valid_reg <= 1'b1;
                if (wi_reg == {LINE_ADDR_BITS{1'b1}})
                    wrapped_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg        <= $signed(s_axis_tdata);
            fwd_hit_reg  <= wr_en && (wr_addr_reg == rd_addr);
            fwd_data_reg <= fed;
            rd_valid_reg <= wrapped_reg || (rd_addr < wi_reg);
        end
        if (state_reg == ST_MAC)
        begin
            y_reg       <= wet_out;
            wr_addr_reg <= wi_reg;
        end
    end

endmodule

`default_nettype wire

// ===== design/dfd_line_mem.sv =====
// Delay line storage: one write port, one read port, registered read data.
// Depends on dfd_pkg for the sample width.
`default_nettype none

module dfd_line_mem #(
    parameter int ADDR_BITS = dfd_pkg::LINE_ADDR_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               wr_en,
    input  wire [ADDR_BITS-1:0]               wr_addr,
    input  wire logic signed [dfd_pkg::DATA_W-1:0] wr_data,
    input  wire                               rd_en,
    input  wire [ADDR_BITS-1:0]               rd_addr,
    output logic signed [dfd_pkg::DATA_W-1:0] rd_data
);
    import dfd_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic signed [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/dfd_mac.sv =====
// Lowpass update and wet/dry mix: two weighted sums of Q1.15 samples.
// Depends on dfd_pkg for widths, the coefficient struct and saturation.
`default_nettype none

module dfd_mac (
    input  wire logic signed [dfd_pkg::DATA_W-1:0] delayed,
    input  wire logic signed [dfd_pkg::DATA_W-1:0] dry,
    input  wire logic signed [dfd_pkg::DATA_W-1:0] lp,
    input  wire dfd_pkg::dfd_coef_t                coef,
    output logic signed [dfd_pkg::DATA_W-1:0]      lp_next,
    output logic signed [dfd_pkg::DATA_W-1:0]      wet_out
);
    import dfd_pkg::*;

    logic signed [DATA_W:0]   dmp_s;
    logic signed [DATA_W:0]   dmp_c;
    logic signed [DATA_W:0]   mix_s;
    logic signed [DATA_W:0]   mix_c;
    logic signed [2*DATA_W:0] lp_p0;
    logic signed [2*DATA_W:0] lp_p1;
    logic signed [2*DATA_W:0] lp_acc;
    logic signed [2*DATA_W:0] mx_p0;
    logic signed [2*DATA_W:0] mx_p1;
    logic signed [2*DATA_W:0] mx_acc;

    // Coefficients and their complements to one
    assign dmp_s = $signed({2'b00, coef.damping});
    assign dmp_c = ONE_Q15 - dmp_s;
    assign mix_s = $signed({1'b0, coef.mix});
    assign mix_c = ONE_Q15 - mix_s;

    // Lowpass: (1-d)*delayed + d*lp, floor shift by 15, saturate
    assign lp_p0  = dmp_c * delayed;
    assign lp_p1  = dmp_s * lp;
    assign lp_acc = lp_p0 + lp_p1;
    assign lp_next = sat_q15($signed(lp_acc[2*DATA_W:DATA_W-1]));

    // Mix: (1-mix)*dry + mix*delayed
    assign mx_p0  = mix_c * dry;
    assign mx_p1  = mix_s * delayed;
    assign mx_acc = mx_p0 + mx_p1;
    assign wet_out = sat_q15($signed(mx_acc[2*DATA_W:DATA_W-1]));

endmodule

`default_nettype wire
